FILE: design/vnu_pkg.sv
// ----------------------------------------------------------------------------
// vnu_pkg
// Shared widths, norm kind codes and control types for the vector norm unit.
// ----------------------------------------------------------------------------
package vnu_pkg;

   localparam int ELEM_W  = 16;               // signed Q8.8 element
   localparam int MAG_W   = ELEM_W + 1;       // |element|, holds 2^(ELEM_W-1)
   localparam int TERM_W  = 2 * MAG_W;        // square of the magnitude
   localparam int TOTAL_W = 41;               // running total
   localparam int NORM_W  = 26;               // result width
   localparam int ROOT_W  = (TOTAL_W + 1) / 2;
   localparam int RAD_W   = 2 * ROOT_W;       // radicand padded to bit pairs
   localparam int REM_W   = ROOT_W + 3;       // partial remainder
   localparam int CNT_W   = $clog2(ROOT_W);

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_INF  = 2'd0;
   localparam kind_type KIND_L1   = 2'd1;
   localparam kind_type KIND_L2   = 2'd2;
   localparam kind_type KIND_NONE = 2'd3;

   // sequencer to accumulator
   typedef struct packed {
      logic     load;    // capture the element
      logic     square;  // form magnitude or square term
      logic     fold;    // fold term into the total
      logic     clear;   // clear the total
      kind_type kind;
   } accum_ctl_type;

   // square root unit to sequencer
   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_stat_type;

endpackage

FILE: design/vnu_accum.sv
// ----------------------------------------------------------------------------
// vnu_accum
// Element register, magnitude/square term stage and saturating running total.
// ----------------------------------------------------------------------------
module vnu_accum
   import vnu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  accum_ctl_type       ctl,
   input  logic [ELEM_W-1:0]   element,
   output logic [TOTAL_W-1:0]  total
);

   logic [ELEM_W-1:0]  element_ff;
   logic [TERM_W-1:0]  term_ff, term_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [MAG_W-1:0]   elem_ext;
   logic [MAG_W-1:0]   mag;
   logic [TOTAL_W:0]   sum;

   assign elem_ext = {element_ff[ELEM_W-1], element_ff};
   assign mag      = element_ff[ELEM_W-1] ? (~elem_ext + MAG_W'(1)) : elem_ext;
   assign sum      = {1'b0, total_ff} + (TOTAL_W + 1)'(term_ff);

   always_comb begin
      term_in = term_ff;
      if (ctl.square) begin
         if (ctl.kind == KIND_L2) begin
            term_in = TERM_W'(mag) * TERM_W'(mag);
         end else begin
            term_in = TERM_W'(mag);
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      if (ctl.clear) begin
         total_in = '0;
      end else if (ctl.fold) begin
         case (ctl.kind)
            KIND_INF: begin
               if (TOTAL_W'(term_ff) > total_ff) total_in = TOTAL_W'(term_ff);
            end
            KIND_L1, KIND_L2: begin
               total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            end
            default: total_in = total_ff;   // unsupported kind adds nothing
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) element_ff <= element;
      term_ff <= term_in;
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   assign total = total_ff;

endmodule

FILE: design/vnu_sqrt.sv
// ----------------------------------------------------------------------------
// vnu_sqrt
// Floor integer square root, one root bit per cycle (restoring, bit pairs).
// ----------------------------------------------------------------------------
module vnu_sqrt
   import vnu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] radicand,
   output sqrt_stat_type      stat
);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = RAD_W'(radicand);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done = done_ff;
   assign stat.root = root_ff;

endmodule

FILE: design/vector_norm_unit.sv
// ----------------------------------------------------------------------------
// vector_norm_unit
// Streamed vector norm (infinity, L1, L2) with one result beat per vector.
// ----------------------------------------------------------------------------
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-----------------------------------
//   req_    | in  | valid / stall      | element, last, empty_req
//   rsp_   | out | valid / stall      | norm (unsigned Q18.8, saturated)
//   csr_    | in  | valid / ready      | norm_kind
//
// Steps: each element beat passes through capture, square, fold and close.
//   A final beat then loads the output register; a final L2 beat first
//   runs the square root: 21 iterations of the shared compare/subtract
//   unit, one root bit each, then a step to pick up the root.
//   An empty-vector beat goes straight to the output register. A result
//   waits there; the next beat is taken once that register has been loaded.
// Reset: synchronous, clears the total, sequencer and output valid; kind
//   comes up as L2.
// ----------------------------------------------------------------------------
module vector_norm_unit
   import vnu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ELEM_W-1:0]  req_element,
   input  logic               req_last,
   input  logic               req_empty_req,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [NORM_W-1:0]  rsp_norm,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  kind_type           csr_norm_kind
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_FOLD,
      ST_CLOSE,
      ST_ROOT,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   kind_type           cfg_kind_ff, cfg_kind_in;
   kind_type           kind_ff, kind_in;
   logic               last_ff, last_in;
   logic [NORM_W-1:0]  res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NORM_W-1:0]  rsp_norm_ff, rsp_norm_in;

   logic               req_beat;
   logic               sqrt_start;
   accum_ctl_type      accum_ctl;
   sqrt_stat_type      sqrt_stat;
   logic [TOTAL_W-1:0] total;
   logic [NORM_W-1:0]  total_sat;

   // kind may be rewritten at any time; each beat latches its own copy
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;

   assign total_sat = (|total[TOTAL_W-1:NORM_W]) ? '1 : total[NORM_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cfg_kind_in  = cfg_kind_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_norm_in  = rsp_norm_ff;
      sqrt_start   = 1'b0;
      accum_ctl    = '{load: 1'b0, square: 1'b0, fold: 1'b0, clear: 1'b0,
                       kind: kind_ff};

      if (csr_valid && csr_ready) cfg_kind_in = csr_norm_kind;
      // output register frees up when its beat is taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               kind_in        = cfg_kind_ff;
               last_in        = req_last;
               accum_ctl.load = 1'b1;
               if (req_empty_req) begin
                  // abandon any vector in progress, result is zero
                  accum_ctl.clear = 1'b1;
                  res_in          = '0;
                  state_in        = ST_EMIT;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            accum_ctl.square = 1'b1;
            state_in         = ST_FOLD;
         end
         ST_FOLD: begin
            accum_ctl.fold = 1'b1;
            state_in       = ST_CLOSE;
         end
         ST_CLOSE: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else begin
               accum_ctl.clear = 1'b1;
               case (kind_ff)
                  KIND_INF, KIND_L1: begin
                     res_in   = total_sat;
                     state_in = ST_EMIT;
                  end
                  KIND_L2: begin
                     sqrt_start = 1'b1;
                     state_in   = ST_ROOT;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_ROOT: begin
            if (sqrt_stat.done) begin
               res_in   = NORM_W'(sqrt_stat.root);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_norm_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      res_ff      <= res_in;
      rsp_norm_ff <= rsp_norm_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_kind_ff  <= KIND_L2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_kind_ff  <= cfg_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_norm  = rsp_norm_ff;

   vnu_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctl     (accum_ctl),
      .element (req_element),
      .total   (total)
   );

   vnu_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (total),
      .stat     (sqrt_stat)
   );

endmodule

FILE: design/vnu_checker.sv
// ----------------------------------------------------------------------------
// vnu_checker
// Port-level checks for vector_norm_unit, bound to the top level.
// ----------------------------------------------------------------------------
module vnu_checker
   import vnu_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_empty_req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [NORM_W-1:0] rsp_norm
);

   // a held result beat keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_norm))
      else $error("result beat changed while stalled");

   // one beat in flight at a time
   a_req_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while busy");

   // empty vector taken with the output register free yields a zero result
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_empty_req && !rsp_valid
      |=> ##1 rsp_valid && rsp_norm == '0)
      else $error("empty vector did not give zero");

   // nothing pending out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind vector_norm_unit vnu_checker u_vnu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_empty_req (req_empty_req),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_norm      (rsp_norm)
);

FILE: bench/vector_norm_unit_checker.sv
// ----------------------------------------------------------------------------
// vector_norm_unit_checker
// Watches the request, result and register channels of the norm unit, keeps
// its own running total and norm kind, and compares every result beat with
// the oldest predicted norm.
// ----------------------------------------------------------------------------
module vector_norm_unit_checker
   import vnu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [ELEM_W-1:0] req_element,
   input  logic              req_last,
   input  logic              req_empty_req,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [NORM_W-1:0] rsp_norm,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  kind_type          csr_norm_kind,
   output int unsigned       error_count,
   output int unsigned       norms_checked,
   output int unsigned       norms_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [NORM_W-1:0] NORM_CEILING = '1;

   kind_type           kind_now;
   logic [TOTAL_W-1:0] total_now;
   logic [NORM_W-1:0]  expected_norms[$];
   int unsigned        mismatches;
   int unsigned        checked;

   // Largest root whose square does not exceed the radicand.
   function automatic logic [ROOT_W-1:0] floor_root(input logic [TOTAL_W-1:0] radicand);
      logic [ROOT_W-1:0] root;
      longint unsigned   trial;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = 64'(root) | (64'd1 << b);
         if (trial * trial <= 64'(radicand)) root = trial[ROOT_W-1:0];
      end
      return root;
   endfunction

   // Folds one beat into the total; returns 1 when the beat yields a norm.
   function automatic bit fold_beat(input logic [ELEM_W-1:0] elem, input logic is_last,
                                    input logic is_empty, output logic [NORM_W-1:0] norm);
      logic [MAG_W-1:0]   mag;
      logic [TERM_W-1:0]  term;
      logic [TOTAL_W:0]   sum;
      logic [TOTAL_W-1:0] closing;
      norm = '0;
      if (is_empty) begin
         total_now = '0;
         return 1'b1;
      end
      mag = {1'b0, elem};
      if (elem[ELEM_W-1]) mag = {1'b1, {ELEM_W{1'b0}}} - mag;
      term = TERM_W'(mag) * TERM_W'(mag);
      case (kind_now)
         KIND_INF: if (mag > total_now) total_now = TOTAL_W'(mag);
         KIND_L1, KIND_L2: begin
            sum = {1'b0, total_now} +
                  ((kind_now == KIND_L1) ? (TOTAL_W + 1)'(mag) : (TOTAL_W + 1)'(term));
            total_now = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
         end
         default: ;
      endcase
      if (!is_last) return 1'b0;
      case (kind_now)
         KIND_INF, KIND_L1: closing = total_now;
         KIND_L2:           closing = TOTAL_W'(floor_root(total_now));
         default:           closing = '0;
      endcase
      norm = (closing > TOTAL_W'(NORM_CEILING)) ? NORM_CEILING : closing[NORM_W-1:0];
      total_now = '0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      logic [NORM_W-1:0] norm;
      logic [NORM_W-1:0] expected;
      if (reset) begin
         kind_now  = KIND_L2;
         total_now = '0;
         expected_norms.delete();
      end else begin
         if (csr_valid && csr_ready) kind_now = csr_norm_kind;
         if (rsp_valid && !rsp_stall) begin
            if (expected_norms.size() == 0) begin
               mismatches++;
               $error("norm: expected none, actual %0d", rsp_norm);
            end else begin
               expected = expected_norms.pop_front();
               checked++;
               if (rsp_norm !== expected) begin
                  mismatches++;
                  $error("norm: expected %0d, actual %0d", expected, rsp_norm);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (fold_beat(req_element, req_last, req_empty_req, norm))
               expected_norms.push_back(norm);
         end
      end
      error_count   <= mismatches;
      norms_checked <= checked;
      norms_pending <= expected_norms.size();
   end

endmodule

FILE: bench/vector_norm_unit_test.sv
// ----------------------------------------------------------------------------
// vector_norm_unit_test
// Drives element beats and norm kind writes into the vector norm unit under
// several idle and stall mixes; a checker beside the block predicts and
// compares every norm, and this module gives the verdict.
// ----------------------------------------------------------------------------
module vector_norm_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vnu_pkg::*;

   // Margin for the block to finish after its last beat: the element steps,
   // plus the square root and hand-off on a closing L2 beat.
   localparam int unsigned DRAIN_CYCLES = 40;
   // Cycles without any beat on any channel before the run is declared hung.
   localparam int unsigned QUIET_LIMIT  = 4000;

   logic              clock;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [ELEM_W-1:0] req_element   = '0;
   logic              req_last      = 1'b0;
   logic              req_empty_req = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic [NORM_W-1:0] rsp_norm;
   logic              csr_valid     = 1'b0;
   logic              csr_ready;
   kind_type          csr_norm_kind = KIND_L2;

   int unsigned error_count;
   int unsigned norms_checked;
   int unsigned norms_pending;

   int unsigned req_idle_pct  = 0;   // chance per cycle the sender holds off
   int unsigned rsp_stall_pct = 0;   // chance per cycle the receiver stalls
   int unsigned beats_sent    = 0;
   int unsigned kind_writes   = 0;
   int unsigned quiet_cycles  = 0;

   vector_norm_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_element   (req_element),
      .req_last      (req_last),
      .req_empty_req (req_empty_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_norm      (rsp_norm),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_norm_kind (csr_norm_kind)
   );

   vector_norm_unit_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_element   (req_element),
      .req_last      (req_last),
      .req_empty_req (req_empty_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_norm      (rsp_norm),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_norm_kind (csr_norm_kind),
      .error_count   (error_count),
      .norms_checked (norms_checked),
      .norms_pending (norms_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver back-pressure, redrawn every cycle at the current phase's rate.
   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Watchdog: any beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d norms still owed",
                  quiet_cycles, norms_pending);
         $display("vector_norm_unit test failed");
         $finish;
      end
   end

   // Mostly random fill, with a good share of corner and near-zero values.
   function automatic logic [ELEM_W-1:0] rand_element();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0:       return {1'b1, {(ELEM_W - 1){1'b0}}};   // most negative
               1:       return {1'b0, {(ELEM_W - 1){1'b1}}};   // most positive
               2:       return '1;                             // -1 lsb
               3:       return ELEM_W'(1);
               default: return '0;
            endcase
         end
         1, 2:    return ELEM_W'($urandom_range(0, 1023) - 512);
         default: return ELEM_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // One request beat. A gap is only inserted before raising valid, so valid
   // is never dropped and re-raised within the same step.
   task automatic send_beat(input logic [ELEM_W-1:0] elem, input logic is_last,
                            input logic is_empty);
      while ((req_idle_pct != 0) && ($urandom_range(0, 99) < req_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_element   <= elem;
      req_last      <= is_last;
      req_empty_req <= is_empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Quiesce: no more requests, every owed norm delivered, then let the
   // block finish any element that yields no result.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (norms_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_kind(input kind_type kind);
      settle();
      csr_valid     <= 1'b1;
      csr_norm_kind <= kind;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      kind_writes++;
   endtask

   // A vector of random content. Now and then an empty-vector beat lands in
   // the middle and abandons it, and now and then the kind changes mid-vector.
   task automatic send_vector(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         if (i != 0 && $urandom_range(0, 39) == 0)
            write_kind(kind_type'($urandom_range(0, 3)));
         if ($urandom_range(0, 29) == 0)
            send_beat(rand_element(), 1'($urandom_range(0, 1)), 1'b1);
         else
            send_beat(rand_element(), i == len - 1, 1'b0);
      end
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned beats);
      int unsigned stop_at;
      int unsigned len;
      stop_at       = beats_sent + beats;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      write_kind(kind_type'($urandom_range(0, 3)));
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 7) == 0) write_kind(kind_type'($urandom_range(0, 3)));
         // mostly short vectors, a few up to 64 elements
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         send_vector(len);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed beats; kind is L2 straight out of reset ----
      send_beat(16'h7FFF, 1'b1, 1'b0);   // largest positive, alone
      send_beat(16'h8000, 1'b1, 1'b0);   // most negative: magnitude 128.0 exactly
      send_beat(16'h1234, 1'b1, 1'b1);   // empty vector, element and last ignored
      send_beat(16'h0100, 1'b0, 1'b0);   // +1.0
      send_beat(16'hFF00, 1'b1, 1'b0);   // -1.0, root of 2.0
      send_beat(16'h0000, 1'b1, 1'b0);   // zero vector

      write_kind(KIND_INF);
      send_beat(16'h0005, 1'b0, 1'b0);
      send_beat(16'h8000, 1'b0, 1'b0);   // max must take the absolute value
      send_beat(16'h0064, 1'b1, 1'b0);

      write_kind(KIND_L1);
      send_beat(16'h0001, 1'b0, 1'b0);
      send_beat(16'hFFFF, 1'b0, 1'b0);
      send_beat(16'h7FFF, 1'b1, 1'b0);
      send_beat(16'h03E8, 1'b0, 1'b0);   // vector abandoned by the empty beat
      send_beat(16'h0000, 1'b0, 1'b1);
      send_beat(16'h0007, 1'b1, 1'b0);   // total must have restarted

      write_kind(KIND_NONE);             // unsupported kind yields zero
      send_beat(16'h01F4, 1'b0, 1'b0);
      send_beat(16'h8000, 1'b1, 1'b0);

      // kind switched between elements of one vector
      write_kind(KIND_L1);
      send_beat(16'h012C, 1'b0, 1'b0);
      write_kind(KIND_L2);
      send_beat(16'h0190, 1'b1, 1'b0);
      send_beat(16'h0321, 1'b0, 1'b0);
      write_kind(KIND_INF);
      send_beat(16'hF000, 1'b1, 1'b0);

      // ---- random vectors under the four idle mixes ----
      run_phase(0, 0, 310);
      run_phase(57, 0, 310);
      run_phase(0, 57, 310);
      run_phase(38, 38, 310);

      settle();
      $display("Covered %0d request beats, %0d norms compared, %0d norm kind writes;",
               beats_sent, norms_checked, kind_writes);
      $display("all four kinds, empty and abandoned vectors, four idle mixes.");
      if (error_count == 0)
         $display("vector_norm_unit test passed");
      else
         $display("vector_norm_unit test failed");
      $finish;
   end

endmodule
